// ===== rtl/gffrc_pkg.sv =====
package gffrc_pkg;

  // fixed field widths of the channels
  localparam int ROW_W      = 6;
  localparam int COL_W      = 6;
  localparam int IN_COLOR_W = 8;
  localparam int FILL_W     = 13;
  localparam int CFG_W      = 7;

  // defaults for the top level parameters
  localparam int DEF_MAX_ROWS   = 64;
  localparam int DEF_MAX_COLS   = 64;
  localparam int DEF_COLOR_BITS = 8;

  // register port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 7'd64;
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // neighbor directions, in visiting order
  localparam logic [1:0] DIR_DOWN  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic clr_step;
    logic load_write;
    logic pass_start;
    logic flood_start;
    logic scan_next;
    logic pop_take;
    logic nb_read;
    logic nb_push;
    logic k_next;
    logic paint_start;
    logic paint_write;
    logic fill_inc;
    logic cmp_start;
    logic cmp_read;
    logic cmp_check;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic in_last;
    logic scan_hit;
    logic scan_last;
    logic nb_in;
    logic nb_hit;
    logic k_last;
    logic q_empty;
    logic paint_last;
    logic out_busy;
  } stat_t;

endpackage

// ===== rtl/gffrc_if.sv =====
// cell load channel
interface gffrc_cell_if import gffrc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ROW_W-1:0]      cell_row;
  logic [COL_W-1:0]      cell_col;
  logic [IN_COLOR_W-1:0] start_color;
  logic [IN_COLOR_W-1:0] wanted_color;
  logic                  last_cell;

  modport source (output valid, cell_row, cell_col, start_color, wanted_color, last_cell,
                  input ready);
  modport sink (input valid, cell_row, cell_col, start_color, wanted_color, last_cell,
                output ready);
endinterface

// result channel
interface gffrc_result_if import gffrc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              grid_matches;
  logic [FILL_W-1:0] fill_count;

  modport source (output valid, grid_matches, fill_count, input ready);
  modport sink (input valid, grid_matches, fill_count, output ready);
endinterface

// ===== rtl/gffrc_dp.sv =====
module gffrc_dp import gffrc_pkg::*; #(
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int COLOR_BITS = DEF_COLOR_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  input  logic [CFG_W-1:0]      rows_cfg,
  input  logic [CFG_W-1:0]      cols_cfg,
  input  logic [ROW_W-1:0]      cell_row,
  input  logic [COL_W-1:0]      cell_col,
  input  logic [IN_COLOR_W-1:0] start_color,
  input  logic [IN_COLOR_W-1:0] wanted_color,
  input  logic                  last_cell,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic                  grid_matches,
  output logic [FILL_W-1:0]     fill_count
);

  localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RNW   = RIW + 1;
  localparam int CNW   = CIW + 1;
  localparam int AW    = RIW + CIW;
  localparam int DEPTH = 1 << AW;
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int QIW   = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int TW    = $clog2(CELLS + 1);

  // size register value, zero counts as one, large values saturate
  function automatic logic [RNW-1:0] clamp_rows(input logic [CFG_W-1:0] v);
    logic [RNW-1:0] r;
    if (v == '0) r = RNW'(1);
    else if (int'(v) > MAX_ROWS) r = RNW'(MAX_ROWS);
    else r = RNW'(v);
    return r;
  endfunction

  function automatic logic [CNW-1:0] clamp_cols(input logic [CFG_W-1:0] v);
    logic [CNW-1:0] r;
    if (v == '0) r = CNW'(1);
    else if (int'(v) > MAX_COLS) r = CNW'(MAX_COLS);
    else r = CNW'(v);
    return r;
  endfunction

  // storage
  logic [COLOR_BITS-1:0] color_mem  [DEPTH];
  logic [COLOR_BITS-1:0] wanted_mem [DEPTH];
  logic                  vis_mem    [DEPTH];
  logic [AW-1:0]         queue_mem  [CELLS];

  // registers
  logic [RIW-1:0]        sr, hr;
  logic [CIW-1:0]        sc, hc;
  logic [1:0]            k;
  logic [TW-1:0]         head, tail;
  logic [RNW-1:0]        rows_l;
  logic [CNW-1:0]        cols_l;
  logic [COLOR_BITS-1:0] region_color, paint, color_q, wanted_q;
  logic [FILL_W-1:0]     fills;
  logic                  match;
  logic [AW-1:0]         clr;
  logic                  vis_q;
  logic [AW-1:0]         q_q;

  // address logic
  logic [AW-1:0]  scan_addr, nb_addr, in_addr, rd_addr;
  logic [RIW-1:0] nr;
  logic [CIW-1:0] nc;
  logic           nb_in, in_range, row_last, col_last;
  logic           color_we, vis_we, vis_wd, queue_we;
  logic [AW-1:0]  color_wa, vis_wa, queue_wd;
  logic [QIW-1:0] queue_wa;
  logic [COLOR_BITS-1:0] color_wd;

  assign scan_addr = {sr, sc};
  assign in_addr   = {RIW'(cell_row), CIW'(cell_col)};
  assign in_range  = (int'(cell_row) < MAX_ROWS) && (int'(cell_col) < MAX_COLS);
  assign row_last  = ({1'b0, sr} + RNW'(1)) == rows_l;
  assign col_last  = ({1'b0, sc} + CNW'(1)) == cols_l;

  // neighbor of the cell being expanded
  always_comb begin
    nr    = hr;
    nc    = hc;
    nb_in = 1'b0;
    case (k)
      DIR_DOWN: begin
        nr    = hr + RIW'(1);
        nb_in = ({1'b0, hr} + RNW'(1)) < rows_l;
      end
      DIR_RIGHT: begin
        nc    = hc + CIW'(1);
        nb_in = ({1'b0, hc} + CNW'(1)) < cols_l;
      end
      DIR_UP: begin
        nr    = hr - RIW'(1);
        nb_in = hr != '0;
      end
      DIR_LEFT: begin
        nc    = hc - CIW'(1);
        nb_in = hc != '0;
      end
      default: nb_in = 1'b0;
    endcase
  end

  assign nb_addr = {nr, nc};
  assign rd_addr = cmd.nb_read ? nb_addr : scan_addr;

  // write port selection
  assign color_we = (cmd.load_write && in_range) || cmd.paint_write;
  assign color_wa = cmd.load_write ? in_addr : q_q;
  assign color_wd = cmd.load_write ? COLOR_BITS'(start_color) : paint;

  assign vis_we = cmd.clr_step || cmd.flood_start || cmd.nb_push || cmd.cmp_read;
  assign vis_wa = cmd.clr_step ? clr : (cmd.nb_push ? nb_addr : scan_addr);
  assign vis_wd = cmd.flood_start || cmd.nb_push;

  assign queue_we = cmd.flood_start || cmd.nb_push;
  assign queue_wa = cmd.flood_start ? '0 : tail[QIW-1:0];
  assign queue_wd = cmd.flood_start ? scan_addr : nb_addr;

  // memories
  always_ff @(posedge clk) begin
    if (color_we) color_mem[color_wa] <= color_wd;
    if (cmd.load_write && in_range) wanted_mem[in_addr] <= COLOR_BITS'(wanted_color);
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    if (queue_we) queue_mem[queue_wa] <= queue_wd;
    color_q  <= color_mem[rd_addr];
    wanted_q <= wanted_mem[scan_addr];
    vis_q    <= vis_mem[rd_addr];
    q_q      <= queue_mem[head[QIW-1:0]];
  end

  // pass registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr   <= '0;
      head  <= '0;
      tail  <= '0;
      k     <= DIR_DOWN;
      sr    <= '0;
      sc    <= '0;
      fills <= '0;
      match <= 1'b1;
    end else begin
      if (cmd.clr_step) clr <= clr + AW'(1);
      if (cmd.pass_start) begin
        rows_l <= clamp_rows(rows_cfg);
        cols_l <= clamp_cols(cols_cfg);
        sr     <= '0;
        sc     <= '0;
        fills  <= '0;
      end
      if (cmd.cmp_start) begin
        sr    <= '0;
        sc    <= '0;
        match <= 1'b1;
      end
      if (cmd.scan_next) begin
        if (col_last) begin
          sc <= '0;
          sr <= sr + RIW'(1);
        end else begin
          sc <= sc + CIW'(1);
        end
      end
      if (cmd.flood_start) begin
        region_color <= color_q;
        paint        <= wanted_q;
        head         <= '0;
        tail         <= TW'(1);
      end
      if (cmd.pop_take) begin
        hr   <= q_q[AW-1:CIW];
        hc   <= q_q[CIW-1:0];
        head <= head + TW'(1);
        k    <= DIR_DOWN;
      end
      if (cmd.k_next) k <= k + 2'd1;
      if (cmd.nb_push) tail <= tail + TW'(1);
      if (cmd.paint_start) head <= '0;
      if (cmd.paint_write) head <= head + TW'(1);
      if (cmd.fill_inc && fills != '1) fills <= fills + FILL_W'(1);
      if (cmd.cmp_check && color_q != wanted_q) match <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      grid_matches <= match;
      fill_count   <= fills;
    end
  end

  // status
  assign stat.clr_done   = clr == '1;
  assign stat.in_last    = last_cell;
  assign stat.scan_hit   = !vis_q && (color_q != wanted_q);
  assign stat.scan_last  = row_last && col_last;
  assign stat.nb_in      = nb_in;
  assign stat.nb_hit     = !vis_q && (color_q == region_color);
  assign stat.k_last     = k == DIR_LEFT;
  assign stat.q_empty    = head == tail;
  assign stat.paint_last = (head + TW'(1)) == tail;
  assign stat.out_busy   = out_valid && !out_ready;

`ifndef SYNTH
  a_head_le_tail: assert property (@(posedge clk) disable iff (rst)
    head <= tail) else $error("queue head passed tail");
  a_no_result_drop: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && !out_ready)) else $error("result overwritten");
  a_push_unvisited: assert property (@(posedge clk) disable iff (rst)
    cmd.nb_push |-> !vis_q) else $error("visited cell queued twice");
`endif

endmodule

// ===== rtl/gffrc_ctrl.sv =====
module gffrc_ctrl import gffrc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [3:0] S_CLR      = 4'd0;
  localparam logic [3:0] S_LOAD     = 4'd1;
  localparam logic [3:0] S_SCAN_RD  = 4'd2;
  localparam logic [3:0] S_SCAN_CHK = 4'd3;
  localparam logic [3:0] S_POP      = 4'd4;
  localparam logic [3:0] S_POP_W    = 4'd5;
  localparam logic [3:0] S_NB       = 4'd6;
  localparam logic [3:0] S_NB_CHK   = 4'd7;
  localparam logic [3:0] S_NEXT     = 4'd8;
  localparam logic [3:0] S_PAINT_RD = 4'd9;
  localparam logic [3:0] S_PAINT_W  = 4'd10;
  localparam logic [3:0] S_CMP_RD   = 4'd11;
  localparam logic [3:0] S_CMP_CHK  = 4'd12;
  localparam logic [3:0] S_OUT      = 4'd13;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLR;
    else state <= state_next;
  end

  // sequencing of load, scan, flood, paint and compare
  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) state_next = S_LOAD;
      end
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_write = 1'b1;
          if (stat.in_last) begin
            cmd.pass_start = 1'b1;
            state_next     = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: state_next = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (stat.scan_hit) begin
          cmd.flood_start = 1'b1;
          state_next      = S_POP;
        end else if (stat.scan_last) begin
          cmd.cmp_start = 1'b1;
          state_next    = S_CMP_RD;
        end else begin
          cmd.scan_next = 1'b1;
          state_next    = S_SCAN_RD;
        end
      end
      S_POP: state_next = S_POP_W;
      S_POP_W: begin
        cmd.pop_take = 1'b1;
        state_next   = S_NB;
      end
      S_NB: begin
        if (stat.nb_in) begin
          cmd.nb_read = 1'b1;
          state_next  = S_NB_CHK;
        end else if (stat.k_last) begin
          state_next = S_NEXT;
        end else begin
          cmd.k_next = 1'b1;
        end
      end
      S_NB_CHK: begin
        cmd.nb_push = stat.nb_hit;
        if (stat.k_last) begin
          state_next = S_NEXT;
        end else begin
          cmd.k_next = 1'b1;
          state_next = S_NB;
        end
      end
      S_NEXT: begin
        if (stat.q_empty) begin
          cmd.paint_start = 1'b1;
          state_next      = S_PAINT_RD;
        end else begin
          state_next = S_POP;
        end
      end
      S_PAINT_RD: state_next = S_PAINT_W;
      S_PAINT_W: begin
        cmd.paint_write = 1'b1;
        if (stat.paint_last) begin
          cmd.fill_inc = 1'b1;
          if (stat.scan_last) begin
            cmd.cmp_start = 1'b1;
            state_next    = S_CMP_RD;
          end else begin
            cmd.scan_next = 1'b1;
            state_next    = S_SCAN_RD;
          end
        end else begin
          state_next = S_PAINT_RD;
        end
      end
      S_CMP_RD: begin
        cmd.cmp_read = 1'b1;
        state_next   = S_CMP_CHK;
      end
      S_CMP_CHK: begin
        cmd.cmp_check = 1'b1;
        if (stat.scan_last) begin
          state_next = S_OUT;
        end else begin
          cmd.scan_next = 1'b1;
          state_next    = S_CMP_RD;
        end
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_LOAD;
        end
      end
      default: state_next = S_CLR;
    endcase
  end

`ifndef SYNTH
  a_last_stops_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && stat.in_last) |=> !in_ready)
    else $error("word taken during fill pass");
  a_scan_step_once: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.scan_next, cmd.cmp_start, cmd.flood_start}))
    else $error("conflicting scan commands");
  a_load_only_idle: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |-> !cmd.load_write)
    else $error("cell written outside of loading");
`endif

endmodule

// ===== rtl/grid_flood_fill_recolor_check.sv =====
// Grid flood-fill recolor check.
// cells: one word per grid cell (row, column, start color, wanted color,
//   last flag), taken one per cycle while the block is loading.
// The word with last_cell set starts a fill pass: a raster scan that
//   floods each unvisited, wrongly colored region (4-connected, same
//   color) through a cell queue, paints it, then compares the grid.
// results: one word per pass with grid_matches and fill_count.
// Pass steps: each scanned cell is read, then checked; each flooded cell
//   is popped, its neighbors are read and checked in turn, then every
//   queued cell is painted with a read and a write; the compare reads
//   and checks each cell. Loading runs at one cell per cycle.
// Reset: the clear steps through all 2^(row bits + column bits) entries
//   (4096 by default) of the visit map; cells.ready stays low until then. Registers reset to 64.
// A stalled result waits in the output register; a following load is
//   still taken, and its pass holds its result until the first is taken.
// Registers: rows_in_use at 0x0, cols_in_use at 0x4; write only while idle.
module grid_flood_fill_recolor_check import gffrc_pkg::*; #(
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int COLOR_BITS = DEF_COLOR_BITS
) (
  input  logic                clk,
  input  logic                rst,
  gffrc_cell_if.sink          cells,
  gffrc_result_if.source      results,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  logic [CFG_W-1:0] rows_in_use, cols_in_use;
  logic             in_ready;
  cmd_t             cmd;
  stat_t            stat;

  // register port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= CFG_SIZE_RESET;
      cols_in_use <= CFG_SIZE_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_ROWS) rows_in_use <= pwdata[CFG_W-1:0];
      if (paddr[2] == REG_COLS) cols_in_use <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_COLS) ? APB_DW'(cols_in_use) : APB_DW'(rows_in_use);

  assign cells.ready = in_ready;

  gffrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cells.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gffrc_dp #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .COLOR_BITS (COLOR_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .rows_cfg     (rows_in_use),
    .cols_cfg     (cols_in_use),
    .cell_row     (cells.cell_row),
    .cell_col     (cells.cell_col),
    .start_color  (cells.start_color),
    .wanted_color (cells.wanted_color),
    .last_cell    (cells.last_cell),
    .out_ready    (results.ready),
    .out_valid    (results.valid),
    .grid_matches (results.grid_matches),
    .fill_count   (results.fill_count)
  );

endmodule
